FILE: rtl/binary_neighbor_threshold_filter_core_macros.svh
// Assertion macros for the binary neighbor threshold filter checker.
// Depends on nothing; included by the checker file only.
`ifndef BINARY_NEIGHBOR_THRESHOLD_FILTER_CORE_MACROS_SVH
`define BINARY_NEIGHBOR_THRESHOLD_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BNT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BNT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bnt_pkg.sv
// Shared constants, types and helpers for the binary neighbor threshold filter.
// No dependencies; compiled first.
`default_nettype none
package bnt_pkg;

  localparam int MAX_SIDE       = 64;
  localparam int MIN_SIDE       = 4;
  localparam int WIN_DEPTH      = 2 * MAX_SIDE + 3;
  localparam int IDX_W          = $clog2(WIN_DEPTH);
  localparam int SIDE_W         = 7;
  localparam int CNT_W          = 13;
  localparam int SUM_W          = 4;
  localparam int FILL_THRESHOLD = 4;
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(16);

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Control for the cell chain, one set per cycle.
  typedef struct packed {
    logic shift;
    logic clr;
    logic din;
  } win_ctl_t;

  // Clamp the programmed side into the supported range.
  function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    r = s;
    if (s < SIDE_W'(MIN_SIDE)) r = SIDE_W'(MIN_SIDE);
    if (s > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bnt_in_if.sv
// Input channel interface: valid/ready handshake with func and cell_req.
// No dependencies.
`default_nettype none
interface bnt_in_if;
  logic valid;
  logic ready;
  logic func;
  logic cell_req;

  modport source (output valid, output func, output cell_req, input ready);
  modport sink   (input valid, input func, input cell_req, output ready);
endinterface
`default_nettype wire

FILE: rtl/bnt_out_if.sv
// Result channel interface: valid/ready handshake with cell_out and last.
// No dependencies.
`default_nettype none
interface bnt_out_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic last;

  modport source (output valid, output cell_out, output last, input ready);
  modport sink   (input valid, input cell_out, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/bnt_cell.sv
// One window cell: a single stored bit, loaded from its upstream neighbor.
// Uses bnt_pkg for the chain control struct.
`default_nettype none
module bnt_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bnt_pkg::win_ctl_t ctl,
  input  wire logic              d,
  output logic                   q
);
  import bnt_pkg::*;

  logic q_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      q_r <= 1'b0;
    end else if (ctl.shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire

FILE: rtl/bnt_window.sv
// Raster window: a chain of bnt_cell instances, newest cell at index 0.
// Uses bnt_pkg and bnt_cell.
`default_nettype none
module bnt_window (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bnt_pkg::win_ctl_t          ctl,
  output logic [bnt_pkg::WIN_DEPTH-1:0]   win
);
  import bnt_pkg::*;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      bnt_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl), .d(ctl.din), .q(win[i]));
    end else begin : g_body
      bnt_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl), .d(win[i-1]), .q(win[i]));
    end
  end
endmodule
`default_nettype wire

FILE: rtl/bnt_vote.sv
// Neighbor vote: picks the eight neighbor taps for the current side and
// thresholds their count. Reads the window as it will be after this shift.
// Uses bnt_pkg.
`default_nettype none
module bnt_vote (
  input  wire logic [bnt_pkg::WIN_DEPTH-1:0] win,
  input  wire logic                          din,
  input  wire logic [bnt_pkg::SIDE_W-1:0]    side,
  output logic                               filled
);
  import bnt_pkg::*;

  logic [IDX_W-1:0] s_idx;
  logic [IDX_W-1:0] s2_idx;
  logic [SUM_W-1:0] sum;

  // Post-shift index k is pre-shift index k-1; index 0 is the incoming bit.
  always_comb begin
    s_idx  = IDX_W'(side);
    s2_idx = IDX_W'({side, 1'b0});
    sum = SUM_W'(din)
        + SUM_W'(win[0])
        + SUM_W'(win[1])
        + SUM_W'(win[s_idx - IDX_W'(1)])
        + SUM_W'(win[s_idx + IDX_W'(1)])
        + SUM_W'(win[s2_idx - IDX_W'(1)])
        + SUM_W'(win[s2_idx])
        + SUM_W'(win[s2_idx + IDX_W'(1)]);
    filled = (sum > SUM_W'(FILL_THRESHOLD));
  end
endmodule
`default_nettype wire

FILE: rtl/binary_neighbor_threshold_filter_core.sv
// Top level of the binary neighbor threshold filter (4-5 cave automaton pass).
// Uses bnt_pkg, bnt_in_if, bnt_out_if, bnt_window, bnt_vote.
//
//   channel | dir | handshake      | payload
//   --------+-----+----------------+--------------------------
//   in_bus  | in  | valid / ready  | func, cell_req
//   out_bus | out | valid / ready  | cell_out, last
//   cfg     | in  | cfg_we         | cfg_wdata (grid_side)
//
// One beat per clock while in_bus.ready is high; a push or full-frame beat shifts
// the chain once and any result lands in the output register on the next edge.
// in_bus.ready drops only while a result sits unclaimed and out_bus.ready is low.
// Results lag input cells by side+1 beats; side+1 drain beats flush a frame.
// Synchronous active-low reset clears the window, both counts and the output
// valid flag; grid_side returns to 16.
`default_nettype none
module binary_neighbor_threshold_filter_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bnt_in_if.sink                           in_bus,
  bnt_out_if.source                        out_bus,
  input  wire logic                        cfg_we,
  input  wire logic [bnt_pkg::SIDE_W-1:0]  cfg_wdata
);
  import bnt_pkg::*;

  logic [SIDE_W-1:0]    grid_side_r;
  logic [CNT_W-1:0]     in_count_r,  in_count_nxt;
  logic [CNT_W-1:0]     out_count_r, out_count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 cell_out_r,  cell_out_nxt;
  logic                 last_r,      last_nxt;

  logic [SIDE_W-1:0]    side;
  logic [CNT_W-1:0]     side_w;
  logic [CNT_W-1:0]     total;
  logic [CNT_W-1:0]     in_cnt_inc;
  logic                 in_ready;
  logic                 accept;
  logic                 full;
  logic                 push;
  logic                 drain_emit;
  logic                 emit;
  logic                 fin;
  logic                 filled;
  win_ctl_t             ctl;
  logic [WIN_DEPTH-1:0] win;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= SIDE_RESET;
    end else if (cfg_we) begin
      grid_side_r <= cfg_wdata;
    end
  end

  // Frame geometry; side <= 64 so side^2 fits the 13-bit count
  assign side   = sat_side(grid_side_r);
  assign side_w = CNT_W'(side);
  assign total  = side_w * side_w;

  // Output register frees up when taken, so input keeps flowing
  assign in_ready     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = in_ready;
  assign accept       = in_bus.valid && in_ready;

  // Beat classification. A push on a full frame acts as a drain;
  // a drain before the frame is full is dropped.
  always_comb begin
    full       = (in_count_r >= total);
    in_cnt_inc = in_count_r + CNT_W'(1);
    push       = accept && (in_bus.func == FUNC_PUSH) && !full;
    drain_emit = accept && full;
    emit       = drain_emit || (push && (in_cnt_inc >= side_w + CNT_W'(2)));
    fin        = emit && (({1'b0, out_count_r} + (CNT_W+1)'(1)) >= {1'b0, total});
    ctl.shift  = push || drain_emit;
    ctl.din    = push ? in_bus.cell_req : 1'b0;
    ctl.clr    = fin;
  end

  bnt_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .win   (win)
  );

  bnt_vote u_vote (
    .win    (win),
    .din    (ctl.din),
    .side   (side),
    .filled (filled)
  );

  // Counts; a final result restarts the frame
  always_comb begin
    in_count_nxt  = in_count_r;
    out_count_nxt = out_count_r;
    if (fin) begin
      in_count_nxt  = '0;
      out_count_nxt = '0;
    end else begin
      if (push) in_count_nxt = in_cnt_inc;
      if (emit) out_count_nxt = out_count_r + CNT_W'(1);
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    cell_out_nxt  = cell_out_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      cell_out_nxt  = filled;
      last_nxt      = fin;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r  <= '0;
      out_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_count_r  <= in_count_nxt;
      out_count_r <= out_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_out_r <= cell_out_nxt;
    last_r     <= last_nxt;
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.cell_out = cell_out_r;
  assign out_bus.last     = last_r;
endmodule
`default_nettype wire

FILE: rtl/bnt_checker.sv
// Port-level checker for the binary neighbor threshold filter, bound to the top.
// Uses binary_neighbor_threshold_filter_core_macros.svh.
`include "binary_neighbor_threshold_filter_core_macros.svh"
`default_nettype none
module bnt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_cell_out,
  input wire logic out_last
);
  // Stalled result beat holds
  `BNT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_cell_out) && $stable(out_last), "stalled result beat changed")

  // Empty output register never blocks input
  `BNT_ASSERT_IMP(a_in_ready, clk, rst_n, !out_valid, in_ready, "input blocked with empty output")

  // A result appears only after an accepted input beat or a held stall
  `BNT_ASSERT_IMP(a_no_invent, clk, rst_n, !$past(in_valid && in_ready) && !$past(out_valid && !out_ready), !out_valid, "result beat without cause")
endmodule

bind binary_neighbor_threshold_filter_core bnt_checker u_bnt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_cell_out (out_bus.cell_out),
  .out_last     (out_bus.last)
);
`default_nettype wire
